### rtl/scft_pkg.sv
// Shared types and constants for the second-chance frame table.
package scft_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_BITS = $clog2(NUM_FRAMES);
    localparam int COUNT_BITS = $clog2(NUM_FRAMES + 1);
    localparam int PAGE_BITS  = 20;
    localparam int OWNER_BITS = 8;

    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_ACCESS = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_FREE_FRAME = 2'd0,
        ST_EVICTED    = 2'd1,
        ST_DONE       = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // Command from the controller to every age-order cell.
    typedef struct packed {
        logic   shift;     // each cell at or beyond gap takes its neighbor
        t_count gap;       // position being removed
        logic   append;    // write tail entry
        t_count tail;      // position to write
        t_frame new_frame;
    } t_cell_cmd;

endpackage

### rtl/second_chance_frame_table_unit.sv
// Top level of the second-chance frame table: controller, frame store and age-order chain.
// Steps to the result strobe: access goes find, done; allocate with a free frame walks frames in
// find; free walks the age order in find, then shifts; allocate under pressure scans, then shifts.
// One request at a time: busy drops in the strobe cycle, so a new request is accepted at the
// earliest at the edge that ends the strobe; the receiver cannot stall.
// Synchronous active-low reset returns to idle and clears in-use and accessed bits, the fill count and the strobe.
module second_chance_frame_table_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_req_type,
    input  logic [5:0]                   i_frame_index,
    input  logic [scft_pkg::PAGE_BITS-1:0]  i_user_page,
    input  logic [scft_pkg::OWNER_BITS-1:0] i_owner_id,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [5:0]                   o_result_frame,
    output logic [19:0]                  o_evicted_page,
    output logic [7:0]                   o_evicted_owner
);
    import scft_pkg::*;

    t_state r_state, n_state;
    logic [NUM_FRAMES-1:0] r_in_use, r_acc;
    logic [PAGE_BITS-1:0]  r_page [NUM_FRAMES];
    logic [OWNER_BITS-1:0] r_owner [NUM_FRAMES];
    t_count r_used, r_k;
    t_req   r_req;
    t_frame r_idx, r_fr;
    logic [PAGE_BITS-1:0]  r_upage, r_evp;
    logic [OWNER_BITS-1:0] r_uown, r_evo;
    t_status r_status;
    logic r_evict, r_valid;

    t_frame    age [NUM_FRAMES];
    t_cell_cmd cmd;

    // Row of age-order cells; each hands its entry to the one nearer the head.
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        t_frame nxt;
        if (g == NUM_FRAMES - 1) begin : g_last
            assign nxt = age[g];
        end else begin : g_mid
            assign nxt = age[g+1];
        end
        scft_age_cell u_cell (
            .i_clk  (i_clk),
            .i_pos  (COUNT_BITS'(g)),
            .i_cmd  (cmd),
            .i_next (nxt),
            .o_frame(age[g])
        );
    end

    t_frame k_frame;
    assign k_frame = age[r_k[FRAME_BITS-1:0]];
    logic k_last;
    assign k_last = (r_k == t_count'(NUM_FRAMES - 1));

    // Chain commands: shift in the shift state, append on completion of an allocate.
    always_comb begin
        cmd = '0;
        cmd.gap       = r_k;
        cmd.tail      = r_used;
        cmd.new_frame = r_fr;
        if (r_state == S_SHIFT) begin
            cmd.shift = 1'b1;
        end
        if (r_state == S_DONE && r_req == REQ_ALLOC) begin
            cmd.append = 1'b1;
            cmd.tail   = r_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_FIND;
            S_FIND: begin
                if (r_req == REQ_ALLOC) begin
                    if (r_used != t_count'(NUM_FRAMES)) begin
                        if (!r_in_use[r_k[FRAME_BITS-1:0]] || k_last) n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (r_req == REQ_FREE && r_in_use[r_idx]) begin
                    if (k_frame == r_idx) n_state = S_SHIFT;
                    else if (k_last) n_state = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN:  if (!r_acc[k_frame] || k_last) n_state = S_SHIFT;
            S_SHIFT: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and table updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_acc    <= '0;
            r_used   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (start) begin
                    r_req   <= t_req'(i_req_type);
                    r_idx   <= i_frame_index;
                    r_upage <= i_user_page;
                    r_uown  <= i_owner_id;
                    r_k     <= '0;
                    r_evict <= 1'b0;
                    r_evp   <= '0;
                    r_evo   <= '0;
                    r_fr    <= i_frame_index;
                end
                S_FIND: begin
                    if (r_req == REQ_ALLOC && r_used != t_count'(NUM_FRAMES)) begin
                        r_fr <= r_k[FRAME_BITS-1:0];
                        if (!(!r_in_use[r_k[FRAME_BITS-1:0]] || k_last))
                            r_k <= r_k + 1'b1;
                        else if (r_in_use[r_k[FRAME_BITS-1:0]])
                            r_fr <= '0;
                    end else if (r_req == REQ_FREE && r_in_use[r_idx]) begin
                        if (k_frame != r_idx) r_k <= r_k + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (!r_acc[k_frame]) begin
                        r_fr <= k_frame;
                    end else if (k_last) begin
                        r_acc[k_frame] <= 1'b0;
                        r_fr <= age[0];
                        r_k  <= '0;
                    end else begin
                        r_acc[k_frame] <= 1'b0;
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SHIFT: begin
                    // Single shift step collapses the whole tail at once.
                    r_used <= r_used - 1'b1;
                    if (r_req == REQ_ALLOC) begin
                        r_evict <= 1'b1;
                        r_evp   <= r_page[r_fr];
                        r_evo   <= r_owner[r_fr];
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    if (r_req == REQ_ALLOC) begin
                        r_in_use[r_fr] <= 1'b1;
                        r_acc[r_fr]    <= 1'b0;
                        r_page[r_fr]   <= r_upage;
                        r_owner[r_fr]  <= r_uown;
                        r_used         <= r_used + 1'b1;
                        r_status       <= r_evict ? ST_EVICTED : ST_FREE_FRAME;
                    end else if (r_req == REQ_FREE && r_in_use[r_idx]) begin
                        r_in_use[r_idx] <= 1'b0;
                        r_acc[r_idx]    <= 1'b0;
                        r_status        <= ST_DONE;
                    end else if (r_req == REQ_ACCESS && r_in_use[r_idx]) begin
                        r_acc[r_idx] <= 1'b1;
                        r_status     <= ST_DONE;
                    end else begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_result_frame  = r_fr;
    assign o_evicted_page  = r_evp;
    assign o_evicted_owner = r_evo;

    // A result strobe follows the completion state.
    a_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_valid) else $error("missing result");
    // The fill count never exceeds the pool.
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= t_count'(NUM_FRAMES)) else $error("fill count overflow");
    // Busy is held for a started request.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request dropped");
endmodule

### rtl/scft_age_cell.sv
// One position of the age order: holds a frame number and shifts toward the head.
module scft_age_cell (
    input  logic                 i_clk,
    input  scft_pkg::t_count     i_pos,
    input  scft_pkg::t_cell_cmd  i_cmd,
    input  scft_pkg::t_frame     i_next,
    output scft_pkg::t_frame     o_frame
);
    import scft_pkg::*;

    t_frame r_frame;

    // Take the neighbor's entry while closing a gap, or the new frame at the tail.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift && i_pos >= i_cmd.gap) begin
            r_frame <= i_next;
        end else if (i_cmd.append && i_pos == i_cmd.tail) begin
            r_frame <= i_cmd.new_frame;
        end
    end

    assign o_frame = r_frame;
endmodule
